### rtl/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Shared types and constants of the spiking neuron step block: microcode
// word layout, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sne_pkg;

  localparam int ACC_W  = 48;
  localparam int SQ_W   = 41;
  localparam int STEP_W = 5;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses: jump targets and the last step
  localparam step_t SUBSTEP_START = 5'd2;
  localparam step_t FINISH_STEP   = 5'd24;
  localparam step_t LAST_STEP     = 5'd24;

  // 0.04 in Q0.16
  localparam logic [15:0] QUAD_COEF = 16'd2621;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENSITIVITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE            = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SYNAPTIC_DECAY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_CURRENT     = 3'd6;

  // register reset values
  localparam logic [15:0]        RATE_RST  = 16'd1311;
  localparam logic [15:0]        SENS_RST  = 16'd13107;
  localparam logic signed [7:0]  CPOT_RST  = -8'sd65;
  localparam logic [23:0]        JUMP_RST  = 24'd524288;
  localparam logic [15:0]        STEP_RST  = 16'd32768;
  localparam logic [15:0]        DECAY_RST = 16'd58982;
  localparam logic signed [31:0] EXT_RST   = 32'sd0;

  typedef struct packed {
    logic [15:0]        recovery_rate;
    logic [15:0]        recovery_sensitivity;
    logic signed [7:0]  reset_potential;
    logic [23:0]        recovery_jump;
    logic [15:0]        step_size;
    logic [15:0]        synaptic_decay;
    logic signed [31:0] external_current;
  } cfg_t;

  typedef enum logic [2:0] {
    MA_V, MA_T, MA_S, MA_SQHI, MA_SQLO
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_V, MB_STEP, MB_SENS, MB_RATE, MB_DECAY, MB_QUAD
  } mul_b_t;

  typedef enum logic [2:0] {
    AX_ZERO, AX_ACC, AX_V, AX_U, AX_S
  } add_x_t;

  typedef enum logic [3:0] {
    AY_ZERO, AY_SYN, AY_STIM, AY_PROD, AY_PROD16, AY_FIVE_V, AY_C140,
    AY_NEG_U, AY_DRV, AY_RESETV, AY_JUMP
  } add_y_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_V, DST_U, DST_S, DST_T, DST_DRV
  } dst_t;

  typedef enum logic [1:0] {
    JC_NONE, JC_AGAIN, JC_NOSPIKE
  } jcond_t;

  typedef struct packed {
    mul_a_t mul_a;
    mul_b_t mul_b;
    logic   sq_en;
    add_x_t add_x;
    add_y_t add_y;
    dst_t   dst;
    jcond_t jcond;
    step_t  target;
    logic   set_spike;
    logic   finish;
  } ucode_t;

endpackage

### rtl/sne_channels.sv
// ----------------------------------------------------------------------------
// sne_channels
// Valid/ready channels of the spiking neuron step block: one tick item in,
// one result item out.
// ----------------------------------------------------------------------------
interface sne_tick_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] synaptic_input;
  logic               stimulus_pulse;
  logic               poisson_pulse;

  modport source (output valid, synaptic_input, stimulus_pulse, poisson_pulse,
                  input ready);
  modport sink (input valid, synaptic_input, stimulus_pulse, poisson_pulse,
                output ready);
endinterface

interface sne_result_if;
  logic               valid;
  logic               ready;
  logic               spike;
  logic signed [31:0] membrane_potential;

  modport source (output valid, spike, membrane_potential, input ready);
  modport sink (input valid, spike, membrane_potential, output ready);
endinterface

### rtl/sne_ucode_rom.sv
// ----------------------------------------------------------------------------
// sne_ucode_rom
// Microprogram of one neuron tick: synaptic sum, drive, two Euler substeps
// (second pass by a loop jump), synaptic decay and spike handling.
// ----------------------------------------------------------------------------
module sne_ucode_rom (
  input  sne_pkg::step_t  step,
  output sne_pkg::ucode_t cw
);

  always_comb begin
    cw = '0;
    case (step)
      // s += synaptic input
      5'd0: begin
        cw.add_x = sne_pkg::AX_S; cw.add_y = sne_pkg::AY_SYN; cw.dst = sne_pkg::DST_S;
      end
      // drive = s + max(stimulus term, poisson term)
      5'd1: begin
        cw.add_x = sne_pkg::AX_S; cw.add_y = sne_pkg::AY_STIM; cw.dst = sne_pkg::DST_DRV;
      end
      // substep: v squared
      5'd2: begin
        cw.mul_a = sne_pkg::MA_V; cw.mul_b = sne_pkg::MB_V;
      end
      5'd3: begin
        cw.sq_en = 1'b1;
      end
      // 0.04 * sq split into high and low halves
      5'd4: begin
        cw.mul_a = sne_pkg::MA_SQHI; cw.mul_b = sne_pkg::MB_QUAD;
      end
      5'd5: begin
        cw.mul_a = sne_pkg::MA_SQLO; cw.mul_b = sne_pkg::MB_QUAD;
        cw.add_x = sne_pkg::AX_ZERO; cw.add_y = sne_pkg::AY_PROD;
      end
      5'd6: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_PROD16;
      end
      5'd7: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_FIVE_V;
      end
      5'd8: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_C140;
      end
      5'd9: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_NEG_U;
      end
      5'd10: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_DRV; cw.dst = sne_pkg::DST_T;
      end
      // v += h * dv
      5'd11: begin
        cw.mul_a = sne_pkg::MA_T; cw.mul_b = sne_pkg::MB_STEP;
      end
      5'd12: begin
        cw.add_x = sne_pkg::AX_V; cw.add_y = sne_pkg::AY_PROD16; cw.dst = sne_pkg::DST_V;
      end
      // diff = b*v - u
      5'd13: begin
        cw.mul_a = sne_pkg::MA_V; cw.mul_b = sne_pkg::MB_SENS;
      end
      5'd14: begin
        cw.add_x = sne_pkg::AX_ZERO; cw.add_y = sne_pkg::AY_PROD16;
      end
      5'd15: begin
        cw.add_x = sne_pkg::AX_ACC; cw.add_y = sne_pkg::AY_NEG_U; cw.dst = sne_pkg::DST_T;
      end
      // du = a * diff
      5'd16: begin
        cw.mul_a = sne_pkg::MA_T; cw.mul_b = sne_pkg::MB_RATE;
      end
      5'd17: begin
        cw.add_x = sne_pkg::AX_ZERO; cw.add_y = sne_pkg::AY_PROD16; cw.dst = sne_pkg::DST_T;
      end
      // u += h * du, then back for the second substep
      5'd18: begin
        cw.mul_a = sne_pkg::MA_T; cw.mul_b = sne_pkg::MB_STEP;
      end
      5'd19: begin
        cw.add_x = sne_pkg::AX_U; cw.add_y = sne_pkg::AY_PROD16; cw.dst = sne_pkg::DST_U;
        cw.jcond = sne_pkg::JC_AGAIN; cw.target = sne_pkg::SUBSTEP_START;
      end
      // synaptic decay, then spike test
      5'd20: begin
        cw.mul_a = sne_pkg::MA_S; cw.mul_b = sne_pkg::MB_DECAY;
      end
      5'd21: begin
        cw.add_x = sne_pkg::AX_ZERO; cw.add_y = sne_pkg::AY_PROD16; cw.dst = sne_pkg::DST_S;
        cw.jcond = sne_pkg::JC_NOSPIKE; cw.target = sne_pkg::FINISH_STEP;
      end
      5'd22: begin
        cw.add_x = sne_pkg::AX_ZERO; cw.add_y = sne_pkg::AY_RESETV; cw.dst = sne_pkg::DST_V;
        cw.set_spike = 1'b1;
      end
      5'd23: begin
        cw.add_x = sne_pkg::AX_U; cw.add_y = sne_pkg::AY_JUMP; cw.dst = sne_pkg::DST_U;
      end
      5'd24: begin
        cw.finish = 1'b1;
      end
      default: begin
        cw = '0;
      end
    endcase
  end

endmodule

### rtl/sne_datapath.sv
// ----------------------------------------------------------------------------
// sne_datapath
// Neuron state and the shared datapath: one registered 32x32 multiplier,
// one saturating adder with an accumulator, driven by the microcode word.
// ----------------------------------------------------------------------------
module sne_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sne_pkg::ucode_t    cw,
  input  sne_pkg::cfg_t      cfg,
  input  logic signed [31:0] syn,
  input  logic               stim,
  input  logic               pois,
  output logic signed [31:0] potential,
  output logic               at_threshold
);

  localparam int ACC_W = sne_pkg::ACC_W;
  localparam int SQ_W  = sne_pkg::SQ_W;
  localparam int UP_SHIFT = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN_SHIFT = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] C140    = ACC_W'(64'sd140 <<< FRAC_BITS);
  localparam logic signed [31:0]      POIS_TERM = 32'(64'sd50 <<< FRAC_BITS);
  localparam logic signed [31:0]      THRESH    = 32'(64'sd30 <<< FRAC_BITS);
  localparam logic [SQ_W-1:0]         SQ_CAP    = SQ_W'(1) << (SQ_W - 1);

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] reset_v(input logic signed [7:0] c);
    logic signed [ACC_W-1:0] w;
    w = {{(ACC_W-8){c[7]}}, c};
    return w <<< FRAC_BITS;
  endfunction

  function automatic logic signed [ACC_W-1:0] jump_q(input logic [23:0] d);
    logic [ACC_W-1:0] w;
    w = {{(ACC_W-24){1'b0}}, d};
    return $signed((w << UP_SHIFT) >> DN_SHIFT);
  endfunction

  logic signed [31:0]      v, u, s, t, drv;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0]      prod;
  logic [SQ_W-1:0]         sq;

  logic signed [31:0]      mul_a, mul_b;
  logic [63:0]             sq_raw;
  logic [SQ_W-1:0]         sq_next;
  logic signed [31:0]      ext_term, pois_term, stim_term;
  logic signed [ACC_W-1:0] prod16, add_x, add_y, sum;
  logic signed [31:0]      sum_sat;

  // multiplier operands
  always_comb begin
    case (cw.mul_a)
      sne_pkg::MA_V:    mul_a = v;
      sne_pkg::MA_T:    mul_a = t;
      sne_pkg::MA_S:    mul_a = s;
      sne_pkg::MA_SQHI: mul_a = $signed({{(32-(SQ_W-16)){1'b0}}, sq[SQ_W-1:16]});
      sne_pkg::MA_SQLO: mul_a = $signed({16'b0, sq[15:0]});
      default:          mul_a = v;
    endcase
    case (cw.mul_b)
      sne_pkg::MB_V:     mul_b = v;
      sne_pkg::MB_STEP:  mul_b = $signed({16'b0, cfg.step_size});
      sne_pkg::MB_SENS:  mul_b = $signed({16'b0, cfg.recovery_sensitivity});
      sne_pkg::MB_RATE:  mul_b = $signed({16'b0, cfg.recovery_rate});
      sne_pkg::MB_DECAY: mul_b = $signed({16'b0, cfg.synaptic_decay});
      sne_pkg::MB_QUAD:  mul_b = $signed({16'b0, sne_pkg::QUAD_COEF});
      default:           mul_b = v;
    endcase
  end

  // v*v is never negative, capped at 2^40
  always_comb begin
    sq_raw  = 64'(prod) >> FRAC_BITS;
    sq_next = (sq_raw > 64'(SQ_CAP)) ? SQ_CAP : sq_raw[SQ_W-1:0];
  end

  always_comb begin
    ext_term  = stim ? cfg.external_current : 32'sd0;
    pois_term = pois ? POIS_TERM : 32'sd0;
    stim_term = (ext_term > pois_term) ? ext_term : pois_term;
    prod16    = ACC_W'(prod >>> 16);
  end

  // adder operands
  always_comb begin
    case (cw.add_x)
      sne_pkg::AX_ZERO: add_x = '0;
      sne_pkg::AX_ACC:  add_x = acc;
      sne_pkg::AX_V:    add_x = ACC_W'(v);
      sne_pkg::AX_U:    add_x = ACC_W'(u);
      sne_pkg::AX_S:    add_x = ACC_W'(s);
      default:          add_x = '0;
    endcase
    case (cw.add_y)
      sne_pkg::AY_ZERO:   add_y = '0;
      sne_pkg::AY_SYN:    add_y = ACC_W'(syn);
      sne_pkg::AY_STIM:   add_y = ACC_W'(stim_term);
      sne_pkg::AY_PROD:   add_y = ACC_W'(prod);
      sne_pkg::AY_PROD16: add_y = prod16;
      sne_pkg::AY_FIVE_V: add_y = (ACC_W'(v) <<< 2) + ACC_W'(v);
      sne_pkg::AY_C140:   add_y = C140;
      sne_pkg::AY_NEG_U:  add_y = -ACC_W'(u);
      sne_pkg::AY_DRV:    add_y = ACC_W'(drv);
      sne_pkg::AY_RESETV: add_y = reset_v(cfg.reset_potential);
      sne_pkg::AY_JUMP:   add_y = jump_q(cfg.recovery_jump);
      default:            add_y = '0;
    endcase
    sum     = add_x + add_y;
    sum_sat = sat32(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= sat32(reset_v(sne_pkg::CPOT_RST));
      u <= sat32(jump_q(sne_pkg::JUMP_RST));
      s <= 32'sd0;
    end else begin
      case (cw.dst)
        sne_pkg::DST_V: v <= sum_sat;
        sne_pkg::DST_U: u <= sum_sat;
        sne_pkg::DST_S: s <= sum_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    acc  <= sum;
    if (cw.sq_en) sq <= sq_next;
    if (cw.dst == sne_pkg::DST_T) t <= sum_sat;
    if (cw.dst == sne_pkg::DST_DRV) drv <= sum_sat;
  end

  assign potential    = v;
  assign at_threshold = (v >= THRESH);

endmodule

### rtl/spiking_neuron_step.sv
// ----------------------------------------------------------------------------
// spiking_neuron_step
// Fixed-point quadratic spiking neuron, one simulation tick per item.
// ----------------------------------------------------------------------------
// Each tick item runs a 25-word microprogram on one shared 32x32 multiplier
// and one saturating adder; a new tick is taken only once the current one
// has finished. The two Euler substeps are one microcode loop run twice;
// the multiplier and the adder are shared by every step. tick.ready is high
// whenever no tick is in flight; the result sits in an output register, so
// the next tick starts while the previous result still waits, and the
// sequencer holds at its last step only if that register is still full.
// Registers are to be written by the user through cfg_write/cfg_index/cfg_data
// only while idle; the block itself does not enforce it.
module spiking_neuron_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  sne_tick_if.sink                       tick,
  sne_result_if.source                   result
);

  sne_pkg::cfg_t   cfg;
  sne_pkg::step_t  step;
  sne_pkg::ucode_t rom_cw, cw;
  logic            busy, pass, spike;
  logic            res_valid, res_spike;
  logic signed [31:0] res_potential;
  logic signed [31:0] syn;
  logic            stim, pois;
  logic signed [31:0] potential;
  logic            at_threshold;
  logic            jump, accept, finish_now;

  sne_ucode_rom u_rom (
    .step (step),
    .cw   (rom_cw)
  );

  // nothing executes between ticks
  assign cw = busy ? rom_cw : '0;

  sne_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cw           (cw),
    .cfg          (cfg),
    .syn          (syn),
    .stim         (stim),
    .pois         (pois),
    .potential    (potential),
    .at_threshold (at_threshold)
  );

  assign accept     = tick.valid && !busy;
  assign finish_now = busy && rom_cw.finish && (!res_valid || result.ready);
  assign jump = ((rom_cw.jcond == sne_pkg::JC_AGAIN) && !pass) ||
                ((rom_cw.jcond == sne_pkg::JC_NOSPIKE) && !at_threshold);

  assign tick.ready                = !busy;
  assign result.valid              = res_valid;
  assign result.spike              = res_spike;
  assign result.membrane_potential = res_potential;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recovery_rate        <= sne_pkg::RATE_RST;
      cfg.recovery_sensitivity <= sne_pkg::SENS_RST;
      cfg.reset_potential      <= sne_pkg::CPOT_RST;
      cfg.recovery_jump        <= sne_pkg::JUMP_RST;
      cfg.step_size            <= sne_pkg::STEP_RST;
      cfg.synaptic_decay       <= sne_pkg::DECAY_RST;
      cfg.external_current     <= sne_pkg::EXT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sne_pkg::REG_RECOVERY_RATE:        cfg.recovery_rate <= cfg_data[15:0];
        sne_pkg::REG_RECOVERY_SENSITIVITY: cfg.recovery_sensitivity <= cfg_data[15:0];
        sne_pkg::REG_RESET_POTENTIAL:      cfg.reset_potential <= $signed(cfg_data[7:0]);
        sne_pkg::REG_RECOVERY_JUMP:        cfg.recovery_jump <= cfg_data[23:0];
        sne_pkg::REG_STEP_SIZE:            cfg.step_size <= cfg_data[15:0];
        sne_pkg::REG_SYNAPTIC_DECAY:       cfg.synaptic_decay <= cfg_data[15:0];
        sne_pkg::REG_EXTERNAL_CURRENT:     cfg.external_current <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      pass      <= 1'b0;
      spike     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (finish_now) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
      if (!busy) begin
        if (accept) begin
          busy  <= 1'b1;
          step  <= '0;
          pass  <= 1'b0;
          spike <= 1'b0;
        end
      end else if (rom_cw.finish) begin
        if (finish_now) busy <= 1'b0;
      end else begin
        if (jump) begin
          step <= rom_cw.target;
          if (rom_cw.jcond == sne_pkg::JC_AGAIN) pass <= 1'b1;
        end else begin
          step <= step + sne_pkg::STEP_W'(1);
        end
        if (rom_cw.set_spike) spike <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      syn  <= tick.synaptic_input;
      stim <= tick.stimulus_pulse;
      pois <= tick.poisson_pulse;
    end
    if (finish_now) begin
      res_spike     <= spike;
      res_potential <= potential;
    end
  end

  // an accepted tick starts at the top of the program
  a_start: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> (busy && step == '0))
    else $error("tick did not start at step zero");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= sne_pkg::LAST_STEP))
    else $error("step counter left the microprogram");

  // a spike can only be flagged after both substeps
  a_spike_after_pass: assert property (@(posedge clk) disable iff (rst)
    spike |-> pass)
    else $error("spike flagged before second substep");

  a_result_at_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> (!busy && $past(busy)))
    else $error("result appeared outside the finish step");

endmodule

### tb/spiking_neuron_step_checker.sv
// ----------------------------------------------------------------------------
// spiking_neuron_step_checker
// Watches the tick and result channels and the register write port of the
// spiking neuron step block. It keeps its own fixed-point copy of the neuron
// (potential, recovery, synaptic current and registers). It predicts the
// result of every accepted tick item and compares each accepted result item,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module spiking_neuron_step_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  sne_tick_if                           tick,
  sne_result_if                         result,
  output int                            errors,
  output int                            pending,
  output int                            spikes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q        = longint'(1) << FRAC_BITS;
  localparam longint SQ_CAP       = longint'(1) << 40;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;
  localparam longint COEF_004     = 2621;

  typedef struct {
    logic               spike;
    logic signed [31:0] potential;
  } tick_out_t;

  // register copies
  longint a_rate, b_sens, c_pot, d_jump, h_step, syn_decay, ext_cur;
  // neuron state
  int v_q, u_q, isyn_q;

  tick_out_t predicted_outputs[$];
  tick_out_t want;
  tick_out_t fresh;

  function automatic int sat_word(longint x);
    if (x > WORD_MAX) return int'(WORD_MAX);
    if (x < WORD_MIN) return int'(WORD_MIN);
    return int'(x);
  endfunction

  // d is held in Q8.16, state in FRAC_BITS fraction bits
  function automatic longint jump_in_q();
    if (FRAC_BITS >= 16) return d_jump << (FRAC_BITS - 16);
    return d_jump >> (16 - FRAC_BITS);
  endfunction

  function automatic void integrate_substep(int drive);
    longint v, sq, dv, bv;
    int     diff, du;
    v  = v_q;
    sq = (v * v) >>> FRAC_BITS;
    if (sq > SQ_CAP) sq = SQ_CAP;
    dv = ((sq * COEF_004) >>> 16) + 5 * v + 140 * ONE_Q - longint'(u_q) + longint'(drive);
    v_q  = sat_word(v + ((longint'(sat_word(dv)) * h_step) >>> 16));
    bv   = (longint'(v_q) * b_sens) >>> 16;
    diff = sat_word(bv - longint'(u_q));
    du   = sat_word((longint'(diff) * a_rate) >>> 16);
    u_q  = sat_word(longint'(u_q) + ((longint'(du) * h_step) >>> 16));
  endfunction

  function automatic tick_out_t advance_tick(int syn, logic stim, logic pois);
    longint    ext, pterm;
    int        drive;
    tick_out_t o;
    ext    = stim ? ext_cur : 64'sd0;
    pterm  = pois ? 50 * ONE_Q : 64'sd0;
    isyn_q = sat_word(longint'(isyn_q) + longint'(syn));
    drive  = sat_word(longint'(isyn_q) + (ext > pterm ? ext : pterm));
    integrate_substep(drive);
    integrate_substep(drive);
    isyn_q = sat_word((longint'(isyn_q) * syn_decay) >>> 16);
    o.spike = 1'b0;
    if (longint'(v_q) >= 30 * ONE_Q) begin
      o.spike = 1'b1;
      v_q = sat_word(c_pot * ONE_Q);
      u_q = sat_word(longint'(u_q) + jump_in_q());
    end
    o.potential = v_q;
    return o;
  endfunction

  function automatic void restore_defaults();
    a_rate    = sne_pkg::RATE_RST;
    b_sens    = sne_pkg::SENS_RST;
    c_pot     = sne_pkg::CPOT_RST;
    d_jump    = sne_pkg::JUMP_RST;
    h_step    = sne_pkg::STEP_RST;
    syn_decay = sne_pkg::DECAY_RST;
    ext_cur   = sne_pkg::EXT_RST;
    v_q    = sat_word(c_pot * ONE_Q);
    u_q    = sat_word(jump_in_q());
    isyn_q = 0;
    predicted_outputs.delete();
  endfunction

  task automatic note_mismatch(string field, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
    errors++;
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
      errors      = 0;
      spikes_seen = 0;
    end else begin
      // a result always belongs to an older tick, so retire it first
      if (result.valid && result.ready) begin
        if (result.spike === 1'b1) spikes_seen++;
        if (predicted_outputs.size() == 0) begin
          errors++;
          $error("result item with no tick waiting: spike %0b potential %0d",
                 result.spike, result.membrane_potential);
        end else begin
          want = predicted_outputs.pop_front();
          if (result.spike !== want.spike)
            note_mismatch("spike", want.spike, result.spike);
          if (result.membrane_potential !== want.potential)
            note_mismatch("membrane_potential", want.potential,
                          result.membrane_potential);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          sne_pkg::REG_RECOVERY_RATE:        a_rate    = cfg_data[15:0];
          sne_pkg::REG_RECOVERY_SENSITIVITY: b_sens    = cfg_data[15:0];
          sne_pkg::REG_RESET_POTENTIAL:      c_pot     = $signed(cfg_data[7:0]);
          sne_pkg::REG_RECOVERY_JUMP:        d_jump    = cfg_data[23:0];
          sne_pkg::REG_STEP_SIZE:            h_step    = cfg_data[15:0];
          sne_pkg::REG_SYNAPTIC_DECAY:       syn_decay = cfg_data[15:0];
          sne_pkg::REG_EXTERNAL_CURRENT:     ext_cur   = $signed(cfg_data);
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        fresh = advance_tick(tick.synaptic_input, tick.stimulus_pulse,
                             tick.poisson_pulse);
        predicted_outputs.insert(predicted_outputs.size(), fresh);
      end
    end
    pending = predicted_outputs.size();
  end

endmodule

### tb/spiking_neuron_step_tb.sv
// ----------------------------------------------------------------------------
// spiking_neuron_step_tb
// Stimulus and verdict for the spiking neuron step block. A directed run hits
// saturation, the stimulus/poisson drive choice and the register extremes;
// then random ticks run under several neuron settings and idle patterns on
// both channels. Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module spiking_neuron_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS     = 16;
  localparam int ONE           = 1 << FRAC_BITS;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_TICKS  = 1750;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [sne_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {SET_CLASSIC, SET_LOW, SET_HIGH, SET_RANDOM} setting_kind_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [sne_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  int errors, pending, spikes_seen;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int settings_applied   = 0;
  int ticks_sent         = 0;

  sne_tick_if   tick_ch();
  sne_result_if result_ch();

  spiking_neuron_step #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  spiking_neuron_step_checker #(.FRAC_BITS(FRAC_BITS)) neuron_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick        (tick_ch),
    .result      (result_ch),
    .errors      (errors),
    .pending     (pending),
    .spikes_seen (spikes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: ready is rolled fresh every cycle
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
      IDLE_BOTH:     begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic signed [31:0] syn, input logic stim,
                           input logic pois);
    while ($urandom_range(99) < sender_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.synaptic_input <= syn;
    tick_ch.stimulus_pulse <= stim;
    tick_ch.poisson_pulse  <= pois;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [sne_pkg::CFG_IDX_W-1:0] idx,
                         input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic load_settings(sne_pkg::cfg_t s);
    bit [31:0] junk;
    junk = $urandom();
    set_reg(sne_pkg::REG_RECOVERY_RATE, {junk[31:16], s.recovery_rate});
    junk = $urandom();
    set_reg(sne_pkg::REG_RECOVERY_SENSITIVITY, {junk[31:16], s.recovery_sensitivity});
    junk = $urandom();
    set_reg(sne_pkg::REG_RESET_POTENTIAL, {junk[31:8], s.reset_potential});
    junk = $urandom();
    set_reg(sne_pkg::REG_RECOVERY_JUMP, {junk[31:24], s.recovery_jump});
    junk = $urandom();
    set_reg(sne_pkg::REG_STEP_SIZE, {junk[31:16], s.step_size});
    junk = $urandom();
    set_reg(sne_pkg::REG_SYNAPTIC_DECAY, {junk[31:16], s.synaptic_decay});
    set_reg(sne_pkg::REG_EXTERNAL_CURRENT, s.external_current);
    junk = $urandom();
    set_reg(REG_UNUSED, junk);
    settings_applied++;
  endtask

  function automatic sne_pkg::cfg_t random_settings(setting_kind_t kind);
    sne_pkg::cfg_t s;
    case (kind)
      SET_CLASSIC: begin
        // usual neuron families: regular, bursting, chattering, fast, low threshold
        case ($urandom_range(4))
          0: {s.recovery_rate, s.recovery_sensitivity, s.reset_potential, s.recovery_jump} =
               {16'd1311, 16'd13107, -8'sd65, 24'd524288};
          1: {s.recovery_rate, s.recovery_sensitivity, s.reset_potential, s.recovery_jump} =
               {16'd1311, 16'd13107, -8'sd55, 24'd262144};
          2: {s.recovery_rate, s.recovery_sensitivity, s.reset_potential, s.recovery_jump} =
               {16'd1311, 16'd13107, -8'sd50, 24'd131072};
          3: {s.recovery_rate, s.recovery_sensitivity, s.reset_potential, s.recovery_jump} =
               {16'd6554, 16'd13107, -8'sd65, 24'd131072};
          default:
             {s.recovery_rate, s.recovery_sensitivity, s.reset_potential, s.recovery_jump} =
               {16'd1311, 16'd16384, -8'sd65, 24'd131072};
        endcase
        s.step_size        = 16'($urandom_range(8192, 40000));
        s.synaptic_decay   = 16'($urandom_range(40000, 65535));
        s.external_current = $urandom_range(0, 20 * ONE);
      end
      SET_LOW: begin
        s.recovery_rate        = '0;
        s.recovery_sensitivity = '0;
        s.reset_potential      = -8'sd128;
        s.recovery_jump        = '0;
        s.step_size            = '0;
        s.synaptic_decay       = '0;
        s.external_current     = 32'sh80000000;
      end
      SET_HIGH: begin
        s.recovery_rate        = '1;
        s.recovery_sensitivity = '1;
        s.reset_potential      = 8'sd127;
        s.recovery_jump        = '1;
        s.step_size            = '1;
        s.synaptic_decay       = '1;
        s.external_current     = 32'sh7FFFFFFF;
      end
      default: begin
        s.recovery_rate        = 16'($urandom());
        s.recovery_sensitivity = 16'($urandom());
        s.reset_potential      = 8'($urandom());
        s.recovery_jump        = 24'($urandom());
        s.step_size            = 16'($urandom());
        s.synaptic_decay       = 16'($urandom());
        s.external_current     = $urandom();
      end
    endcase
    return s;
  endfunction

  function automatic setting_kind_t phase_kind(int p);
    case (p)
      1:       return SET_HIGH;
      3:       return SET_LOW;
      4, 6:    return SET_RANDOM;
      default: return SET_CLASSIC;
    endcase
  endfunction

  // mostly modest synaptic input so the neuron fires now and then
  task automatic random_tick();
    int                 r;
    logic signed [31:0] syn;
    logic               stim, pois;
    r = $urandom_range(99);
    if (r < 60)      syn = int'($urandom_range(0, 18 * ONE)) - 8 * ONE;
    else if (r < 75) syn = 0;
    else if (r < 85) syn = int'($urandom_range(0, 2 * ONE)) - ONE;
    else if (r < 95) syn = $urandom();
    else             syn = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    stim = ($urandom_range(99) < 40);
    pois = ($urandom_range(99) < 15);
    send_tick(syn, stim, pois);
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    tick_ch.valid          = 1'b0;
    tick_ch.synaptic_input = '0;
    tick_ch.stimulus_pulse = 1'b0;
    tick_ch.poisson_pulse  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idle(IDLE_NONE);
    // quiescent, stimulus with zero current, poisson drive, both flags
    send_tick(0, 1'b0, 1'b0);
    send_tick(0, 1'b1, 1'b0);
    send_tick(0, 1'b0, 1'b1);
    send_tick(0, 1'b1, 1'b1);
    // synaptic current saturating both ways
    send_tick(32'sh7FFFFFFF, 1'b0, 1'b0);
    send_tick(32'sh7FFFFFFF, 1'b1, 1'b1);
    send_tick(32'sh80000000, 1'b0, 1'b0);
    send_tick(32'sh80000000, 1'b0, 1'b0);
    send_tick(32'sh80000000, 1'b1, 1'b1);
    send_tick(3 * ONE, 1'b0, 1'b0);
    wait_drained();
    // negative stimulus current loses against the poisson term
    set_reg(sne_pkg::REG_EXTERNAL_CURRENT, -5 * ONE);
    send_tick(0, 1'b1, 1'b0);
    send_tick(0, 1'b1, 1'b1);
    wait_drained();
    set_reg(sne_pkg::REG_EXTERNAL_CURRENT, 32'h7FFFFFFF);
    set_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_tick(0, 1'b1, 1'b0);
    send_tick(0, 1'b1, 1'b1);
    wait_drained();
    set_reg(sne_pkg::REG_EXTERNAL_CURRENT, 32'h80000000);
    set_reg(sne_pkg::REG_RESET_POTENTIAL, 32'hFFFFFF7F);
    set_reg(sne_pkg::REG_RECOVERY_JUMP, 32'hFFFFFFFF);
    send_tick(0, 1'b1, 1'b0);
    send_tick(20 * ONE, 1'b0, 1'b1);
    send_tick(20 * ONE, 1'b0, 1'b1);
    wait_drained();
    set_reg(sne_pkg::REG_RESET_POTENTIAL, 32'h00000080);
    set_reg(sne_pkg::REG_STEP_SIZE, 32'h0000FFFF);
    send_tick(40 * ONE, 1'b0, 1'b1);
    send_tick(0, 1'b1, 1'b1);
    send_tick(-40 * ONE, 1'b0, 1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_idle(idle_mode_t'(p % 4));
      load_settings(random_settings(phase_kind(p)));
      for (int i = 0; i < RANDOM_TICKS / PHASES; i++) begin
        random_tick();
        // hold the sender off once until every result is out
        if (p == 2 && i == RANDOM_TICKS / PHASES / 2) wait_drained();
      end
      wait_drained();
    end

    $display("ran %0d tick items over %0d full register settings and all idle patterns",
             ticks_sent, settings_applied);
    $display("neuron fired %0d times, %0d mismatches counted", spikes_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sne_pkg.sv
rtl/sne_channels.sv
rtl/sne_ucode_rom.sv
rtl/sne_datapath.sv
rtl/spiking_neuron_step.sv
tb/spiking_neuron_step_checker.sv
tb/spiking_neuron_step_tb.sv
